@@ rtl/uasp_command_iu_decoder_defines.svh @@
// Assertion macros shared by the command IU decoder RTL.
`ifndef UASP_COMMAND_IU_DECODER_DEFINES_SVH
`define UASP_COMMAND_IU_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define UCID_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define UCID_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/ucid_pkg.sv @@
// Types, codes and the command table of the UASP command IU decoder.
`default_nettype none
package ucid_pkg;

    // Configuration port
    localparam int unsigned PaddrW = 3;
    localparam int unsigned PdataW = 32;
    localparam logic [3:0]  BlockSizeLog2Reset = 4'd9;

    // Outcome codes
    localparam logic [1:0] OUTC_ACCEPTED = 2'd0;
    localparam logic [1:0] OUTC_UNKNOWN  = 2'd1;
    localparam logic [1:0] OUTC_BAD_ATTR = 2'd2;
    localparam logic [1:0] OUTC_BAD_IU   = 2'd3;

    // Transfer direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_IN   = 2'd1;
    localparam logic [1:0] DIR_OUT  = 2'd2;

    localparam logic [7:0] IU_COMMAND  = 8'h01;
    localparam logic [2:0] ATTR_SIMPLE = 3'd0;
    localparam logic [7:0] OP_READ_CAPACITY_16 = 8'h9E;
    localparam logic [4:0] SA_READ_CAPACITY_16 = 5'h10;

    // Count field sizes in bytes
    localparam logic [2:0] FIELD_W1 = 3'd1;
    localparam logic [2:0] FIELD_W2 = 3'd2;
    localparam logic [2:0] FIELD_W4 = 3'd4;

    typedef struct packed {
        logic [7:0]  iu_type;
        logic [2:0]  task_attribute;
        logic [15:0] stream_tag;
        logic [7:0]  lun_top_byte;
        logic [63:0] cdb_front;
        logic [63:0] cdb_back;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [1:0]  transfer_direction;
        logic [4:0]  cdb_length;
        logic [31:0] expected_bytes;
        logic [15:0] tag_out;
        logic [7:0]  lun_out;
    } t_out_item;

    // One decoded table row
    typedef struct packed {
        logic       hit;
        logic [4:0] len;
        logic [1:0] dir;
        logic       blocks;
        logic       from_cdb;
        logic [3:0] fixed;
        logic [3:0] pos;
        logic [2:0] width;
    } t_cmd_entry;

    // After lookup stage
    typedef struct packed {
        logic [1:0]   outcome;
        t_cmd_entry   entry;
        logic [127:0] cdb;
        logic [15:0]  tag;
        logic [7:0]   lun;
    } t_s1;

    // After count extraction stage
    typedef struct packed {
        logic [1:0]  outcome;
        logic [1:0]  dir;
        logic [4:0]  len;
        logic        blocks;
        logic [31:0] count;
        logic [15:0] tag;
        logic [7:0]  lun;
    } t_s2;

    function automatic t_cmd_entry mk_entry(
        input logic [4:0] len,
        input logic [1:0] dir,
        input logic       blocks,
        input logic       from_cdb,
        input logic [3:0] fixed,
        input logic [3:0] pos,
        input logic [2:0] width
    );
        t_cmd_entry e;
        e.hit      = 1'b1;
        e.len      = len;
        e.dir      = dir;
        e.blocks   = blocks;
        e.from_cdb = from_cdb;
        e.fixed    = fixed;
        e.pos      = pos;
        e.width    = width;
        return e;
    endfunction

    // Fixed command table keyed by opcode; service action only for READ CAPACITY 16
    function automatic t_cmd_entry cmd_lookup(input logic [7:0] op, input logic [4:0] sa);
        t_cmd_entry e;
        e = '0;
        case (op)
            8'h12: e = mk_entry(5'd6,  DIR_IN,   1'b0, 1'b1, 4'd0, 4'd3,  FIELD_W2);
            8'h15: e = mk_entry(5'd6,  DIR_OUT,  1'b0, 1'b1, 4'd0, 4'd4,  FIELD_W1);
            8'h55: e = mk_entry(5'd10, DIR_OUT,  1'b0, 1'b1, 4'd0, 4'd7,  FIELD_W2);
            8'h1A: e = mk_entry(5'd6,  DIR_IN,   1'b0, 1'b1, 4'd0, 4'd4,  FIELD_W1);
            8'h5A: e = mk_entry(5'd10, DIR_IN,   1'b0, 1'b1, 4'd0, 4'd7,  FIELD_W2);
            8'hA0: e = mk_entry(5'd12, DIR_IN,   1'b0, 1'b1, 4'd0, 4'd6,  FIELD_W4);
            8'h03: e = mk_entry(5'd6,  DIR_IN,   1'b0, 1'b1, 4'd0, 4'd4,  FIELD_W1);
            8'h1D: e = mk_entry(5'd6,  DIR_OUT,  1'b0, 1'b1, 4'd0, 4'd3,  FIELD_W2);
            8'h00: e = mk_entry(5'd6,  DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h08: e = mk_entry(5'd6,  DIR_IN,   1'b1, 1'b1, 4'd0, 4'd4,  FIELD_W1);
            8'h28: e = mk_entry(5'd10, DIR_IN,   1'b1, 1'b1, 4'd0, 4'd7,  FIELD_W2);
            8'hA8: e = mk_entry(5'd12, DIR_IN,   1'b1, 1'b1, 4'd0, 4'd6,  FIELD_W4);
            8'h88: e = mk_entry(5'd16, DIR_IN,   1'b1, 1'b1, 4'd0, 4'd10, FIELD_W4);
            8'h0A: e = mk_entry(5'd6,  DIR_OUT,  1'b1, 1'b1, 4'd0, 4'd4,  FIELD_W1);
            8'h2A: e = mk_entry(5'd10, DIR_OUT,  1'b1, 1'b1, 4'd0, 4'd7,  FIELD_W2);
            8'hAA: e = mk_entry(5'd12, DIR_OUT,  1'b1, 1'b1, 4'd0, 4'd6,  FIELD_W4);
            8'h8A: e = mk_entry(5'd16, DIR_OUT,  1'b1, 1'b1, 4'd0, 4'd10, FIELD_W4);
            8'h1E: e = mk_entry(5'd6,  DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h25: e = mk_entry(5'd10, DIR_IN,   1'b0, 1'b0, 4'd8, 4'd0,  3'd0);
            8'h9E: begin
                if (sa == SA_READ_CAPACITY_16) begin
                    e = mk_entry(5'd16, DIR_IN, 1'b0, 1'b1, 4'd0, 4'd10, FIELD_W4);
                end
            end
            8'h1B: e = mk_entry(5'd6,  DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h2F: e = mk_entry(5'd10, DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'hAF: e = mk_entry(5'd12, DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h8F: e = mk_entry(5'd16, DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h04: e = mk_entry(5'd6,  DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h35: e = mk_entry(5'd10, DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            8'h91: e = mk_entry(5'd16, DIR_NONE, 1'b0, 1'b0, 4'd0, 4'd0,  3'd0);
            default: e = '0;
        endcase
        return e;
    endfunction

    // CDB byte k of the 16-byte block, byte 0 in the top bits
    function automatic logic [7:0] cdb_byte(input logic [127:0] cdb, input logic [3:0] k);
        logic [7:0] b;
        b = cdb[8'd127 - {k, 3'b000} -: 8];
        return b;
    endfunction

endpackage
`default_nettype wire

@@ rtl/ucid_lookup.sv @@
// Stage 1: IU type and attribute checks, opcode table lookup.
`default_nettype none
module ucid_lookup
    import ucid_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    output logic          o_stall,
    output logic          o_valid,
    output t_s1           o_data,
    input  wire logic     i_stall
);

    logic       r_valid;
    t_s1        r_data;
    t_s1        n_data;
    logic       w_adv;
    t_cmd_entry w_entry;

    // Stage moves when empty or when downstream takes its transaction
    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;

    // Checks in priority order: IU type, attribute, table hit
    always_comb begin
        w_entry = cmd_lookup(i_data.cdb_front[63:56], i_data.cdb_front[52:48]);
        n_data.entry = w_entry;
        n_data.cdb   = {i_data.cdb_front, i_data.cdb_back};
        n_data.tag   = i_data.stream_tag;
        n_data.lun   = i_data.lun_top_byte;
        if (i_data.iu_type != IU_COMMAND) begin
            n_data.outcome = OUTC_BAD_IU;
        end else if (i_data.task_attribute != ATTR_SIMPLE) begin
            n_data.outcome = OUTC_BAD_ATTR;
        end else if (!w_entry.hit) begin
            n_data.outcome = OUTC_UNKNOWN;
        end else begin
            n_data.outcome = OUTC_ACCEPTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ rtl/ucid_extract.sv @@
// Stage 2: big-endian count field extraction from the CDB.
`default_nettype none
module ucid_extract
    import ucid_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s1  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_s2       o_data,
    input  wire logic i_stall
);

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic        w_adv;
    logic [7:0]  w_b0;
    logic [7:0]  w_b1;
    logic [7:0]  w_b2;
    logic [7:0]  w_b3;
    logic [31:0] w_field;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;

    // Four consecutive bytes from pos, offsets wrap within the 16-byte CDB
    always_comb begin
        w_b0 = cdb_byte(i_data.cdb, i_data.entry.pos);
        w_b1 = cdb_byte(i_data.cdb, i_data.entry.pos + 4'd1);
        w_b2 = cdb_byte(i_data.cdb, i_data.entry.pos + 4'd2);
        w_b3 = cdb_byte(i_data.cdb, i_data.entry.pos + 4'd3);
        case (i_data.entry.width)
            FIELD_W1: w_field = {24'd0, w_b0};
            FIELD_W2: w_field = {16'd0, w_b0, w_b1};
            FIELD_W4: w_field = {w_b0, w_b1, w_b2, w_b3};
            default:  w_field = 32'd0;
        endcase
    end

    // Rejected commands carry zero direction, length and count
    always_comb begin
        n_data.outcome = i_data.outcome;
        n_data.tag     = i_data.tag;
        n_data.lun     = i_data.lun;
        if (i_data.outcome == OUTC_ACCEPTED) begin
            n_data.dir    = i_data.entry.dir;
            n_data.len    = i_data.entry.len;
            n_data.blocks = i_data.entry.blocks;
            n_data.count  = i_data.entry.from_cdb ? w_field : {28'd0, i_data.entry.fixed};
        end else begin
            n_data.dir    = DIR_NONE;
            n_data.len    = 5'd0;
            n_data.blocks = 1'b0;
            n_data.count  = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ rtl/ucid_scale.sv @@
// Stage 3: block count to byte count scaling and the output register.
`default_nettype none
module ucid_scale
    import ucid_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [3:0] i_block_size_log2,
    input  wire logic       i_valid,
    input  wire t_s2        i_data,
    output logic            o_stall,
    output logic            o_valid,
    output t_out_item       o_data,
    input  wire logic       i_stall
);

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;
    logic      w_adv;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;

    // Block counts shift by the block size exponent, wrapping at 32 bits
    always_comb begin
        n_data.outcome            = i_data.outcome;
        n_data.transfer_direction = i_data.dir;
        n_data.cdb_length         = i_data.len;
        n_data.expected_bytes     = i_data.blocks ? (i_data.count << i_block_size_log2)
                                                  : i_data.count;
        n_data.tag_out            = i_data.tag;
        n_data.lun_out            = i_data.lun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ rtl/uasp_command_iu_decoder.sv @@
// Throughput: one transaction per cycle while the output is not stalled; a three-stage
// pipeline (lookup, field extraction, scaling) with per-stage valid bits, so a stall at
// the output backs up stage by stage without losing or repeating a transaction.
// Reset (i_rst_n low, synchronous) empties all stages and sets block_size_log2 to 9.
`default_nettype none
`include "uasp_command_iu_decoder_defines.svh"
module uasp_command_iu_decoder
    import ucid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Command IU channel
    input  wire logic              i_in_valid,
    input  wire t_in_item          i_in,
    output logic                   o_in_stall,
    // Result channel
    output logic                   o_out_valid,
    output t_out_item              o_out,
    input  wire logic              i_out_stall,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [PdataW-1:0] pwdata,
    output logic [PdataW-1:0]      prdata,
    output logic                   pready
);

    logic [3:0] r_block_size_log2;
    logic       w_cfg_wr;
    logic       w_s1_valid;
    t_s1        w_s1_data;
    logic       w_s1_stall;
    logic       w_s2_valid;
    t_s2        w_s2_data;
    logic       w_s2_stall;

    // Register 0 sits at byte address 0; higher word addresses hold nothing
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? '0 : {{(PdataW-4){1'b0}}, r_block_size_log2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size_log2 <= BlockSizeLog2Reset;
        end else if (w_cfg_wr) begin
            r_block_size_log2 <= pwdata[3:0];
        end
    end

    ucid_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in),
        .o_stall (o_in_stall),
        .o_valid (w_s1_valid),
        .o_data  (w_s1_data),
        .i_stall (w_s1_stall)
    );

    ucid_extract u_extract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_data  (w_s1_data),
        .o_stall (w_s1_stall),
        .o_valid (w_s2_valid),
        .o_data  (w_s2_data),
        .i_stall (w_s2_stall)
    );

    ucid_scale u_scale (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_block_size_log2 (r_block_size_log2),
        .i_valid           (w_s2_valid),
        .i_data            (w_s2_data),
        .o_stall           (w_s2_stall),
        .o_valid           (o_out_valid),
        .o_data            (o_out),
        .i_stall           (i_out_stall)
    );

    // Rejected commands report no direction, length or byte count
    `UCID_ASSERT_NOW(a_reject_zero, o_out_valid && (o_out.outcome != OUTC_ACCEPTED), (o_out.transfer_direction == DIR_NONE) && (o_out.cdb_length == 5'd0) && (o_out.expected_bytes == 32'd0), "rejected command with nonzero fields")

    // Every accepted command has a table CDB length
    `UCID_ASSERT_NOW(a_accept_len, o_out_valid && (o_out.outcome == OUTC_ACCEPTED), (o_out.cdb_length != 5'd0), "accepted command with zero CDB length")

    // Input is held off only when the full pipeline waits on the output
    `UCID_ASSERT_NOW(a_stall_source, o_in_stall, o_out_valid && i_out_stall, "input stalled without output backpressure")

    // A configuration write lands in the block size register
    `UCID_ASSERT_NEXT(a_cfg_write, w_cfg_wr, r_block_size_log2 == $past(pwdata[3:0]), "block size write lost")

endmodule
`default_nettype wire
